@@ hdl/mbd_pkg.sv @@
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants and types for the 2x2 box-filter mip level downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int CHAN_W  = 8;
  localparam int TEXEL_W = 4 * CHAN_W;
  localparam int PSUM_W  = CHAN_W + 1;
  localparam int PAIR_W  = 4 * PSUM_W;
  localparam int TOTAL_W = CHAN_W + 2;

  localparam int DIM_REG_W  = 12;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 12'd256;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd4
  } reg_addr_t;

  // Item held between the input register stage and the result register.
  typedef struct packed {
    logic              vld;
    logic              h_one;
    logic              last;
    logic [PAIR_W-1:0] pair;
  } stage_t;

endpackage : mbd_pkg

`default_nettype wire

@@ hdl/mipmap_box_downsample_top.sv @@
// ----------------------------------------------------------------------------
// mipmap_box_downsample_top
// Builds the next mip level with a 2x2 box filter over a raster texel stream.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Content
// --------  ---------  -----------------------------------------------------
// in_*      sink       one source RGBA texel per item, raster order
// out_*     source     one next-level texel per item, tlast on frame end
// cfg_*     APB slave  source_width at 0x0, source_height at 0x4
//
// One item is accepted per clock while in_tready is high. The odd texel that
// completes a 2x2 block passes through the pair-sum register and line store
// read, then its result through the result register. The line store is a
// single-port memory with a registered read. Reset restores both sizes to 256
// and clears the counters, the held texel and the valid flags, not the store.
// A stalled output holds the result register, and input ready drops once the
// pair stage also holds a result. A register write restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module mipmap_box_downsample_top
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: in_red[7:0], in_green[15:8], in_blue[23:16], in_alpha[31:24]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [TEXEL_W-1:0]    in_tdata,
  // out_tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [TEXEL_W-1:0]         out_tdata,
  output logic                       out_tlast,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  // Configuration registers.
  logic [DIM_REG_W-1:0] src_w_r, src_h_r;
  logic                 cfg_wr;

  // Frame position and pairing state.
  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [TEXEL_W-1:0] left_r, left_nxt;

  logic [WW-1:0] w_eff, ow_m1;
  logic [HW-1:0] h_eff, oh_m1;
  logic          w_one, h_one;

  logic              in_acc;
  logic              s1_adv;
  logic              have_pair;
  logic [PAIR_W-1:0] pair;
  logic [AW-1:0]     ox;
  logic [RW-1:0]     oy;
  logic              row_odd;
  logic              st_wr;
  logic              emit;
  logic              is_last;

  stage_t            s1_r, s1_nxt;
  logic [PAIR_W-1:0] store [DEPTH];
  logic [PAIR_W-1:0] rd_r;

  logic               out_v_r, out_v_nxt;
  logic [TEXEL_W-1:0] out_d_r, out_d_nxt;
  logic               out_l_r, out_l_nxt;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_RESET;
      src_h_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        REG_SOURCE_WIDTH:  src_w_r <= cfg_pwdata[DIM_REG_W-1:0];
        REG_SOURCE_HEIGHT: src_h_r <= cfg_pwdata[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      REG_SOURCE_WIDTH:  cfg_prdata = CFG_DATA_W'(src_w_r);
      REG_SOURCE_HEIGHT: cfg_prdata = CFG_DATA_W'(src_h_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // A zero size acts as one; a size above the maximum acts as the maximum.
  always_comb begin
    if (src_w_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(src_w_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(src_w_r);
    end
    if (src_h_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(src_h_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(src_h_r);
    end
  end

  assign w_one = (w_eff == WW'(1));
  assign h_one = (h_eff == HW'(1));
  assign ow_m1 = w_one ? '0 : (w_eff >> 1) - WW'(1);
  assign oh_m1 = h_one ? '0 : (h_eff >> 1) - HW'(1);

  // ------------------------------------------------------------ handshake
  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_r.vld || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // ----------------------------------------------------------- pair stage
  always_comb begin
    left_nxt  = left_r;
    have_pair = 1'b0;
    pair      = '0;
    ox        = AW'(col_r >> 1);
    if (w_one) begin
      // A single column pairs each texel with itself.
      for (int c = 0; c < 4; c++) begin
        pair[c*PSUM_W +: PSUM_W] = {in_tdata[c*CHAN_W +: CHAN_W], 1'b0};
      end
      have_pair = 1'b1;
      ox        = '0;
    end else if (!col_r[0]) begin
      left_nxt = in_tdata;
    end else begin
      for (int c = 0; c < 4; c++) begin
        pair[c*PSUM_W +: PSUM_W] = PSUM_W'(left_r[c*CHAN_W +: CHAN_W]) +
                                   PSUM_W'(in_tdata[c*CHAN_W +: CHAN_W]);
      end
      have_pair = 1'b1;
    end
  end

  assign row_odd = row_r[0];
  assign oy      = row_r >> 1;
  assign st_wr   = in_acc && have_pair && !h_one && !row_odd;
  assign emit    = have_pair && (h_one || row_odd);
  assign is_last = (32'(ox) == 32'(ow_m1)) && (32'(oy) == 32'(oh_m1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (32'(col_r) + 32'd1 >= 32'(w_eff)) begin
        col_nxt = '0;
        row_nxt = (32'(row_r) + 32'd1 >= 32'(h_eff)) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_comb begin
    s1_nxt = s1_r;
    if (in_acc) begin
      s1_nxt.vld   = emit;
      s1_nxt.h_one = h_one;
      s1_nxt.last  = is_last;
      s1_nxt.pair  = pair;
    end else if (s1_adv) begin
      s1_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= s1_nxt.vld;
    end
    s1_r.h_one <= s1_nxt.h_one;
    s1_r.last  <= s1_nxt.last;
    s1_r.pair  <= s1_nxt.pair;
  end

  // Line store of even-row pair sums. The read data stays put while stalled.
  always_ff @(posedge clk) begin
    if (st_wr) begin
      store[ox] <= pair;
    end
    if (in_acc) begin
      rd_r <= store[ox];
    end
  end

  // ---------------------------------------------------------- result stage
  always_comb begin
    logic [TOTAL_W-1:0] tot;
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    out_l_nxt = out_l_r;
    tot       = '0;
    if (s1_adv) begin
      out_v_nxt = s1_r.vld;
      out_l_nxt = s1_r.last;
      for (int c = 0; c < 4; c++) begin
        if (s1_r.h_one) begin
          tot = {s1_r.pair[c*PSUM_W +: PSUM_W], 1'b0};
        end else begin
          tot = TOTAL_W'(rd_r[c*PSUM_W +: PSUM_W]) +
                TOTAL_W'(s1_r.pair[c*PSUM_W +: PSUM_W]);
        end
        out_d_nxt[c*CHAN_W +: CHAN_W] = tot[TOTAL_W-1:2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
    out_d_r <= out_d_nxt;
    out_l_r <= out_l_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;

endmodule : mipmap_box_downsample_top

`default_nettype wire
